[hw/rtl/pollard_rho_brent_factor64_defines.svh]
// ----------------------------------------------------------------------------
// Pollard rho factor splitter: assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POLLARD_RHO_BRENT_FACTOR64_DEFINES_SVH
`define POLLARD_RHO_BRENT_FACTOR64_DEFINES_SVH

// same-cycle implication
`define PRBF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PRBF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/prbf_pkg.sv]
// ----------------------------------------------------------------------------
// Pollard rho factor splitter: package
// Widths, constants and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prbf_pkg;

	localparam int NUM_W            = 64;
	localparam int SEED_W           = 48;
	localparam int ROUND_BASE_SHIFT = 18;
	localparam int STEP_FLOOR       = 1000;
	localparam int MIN_ROUNDS       = 3;
	localparam int EXP_CAP          = 31;
	localparam int EXP_W            = 5;
	localparam int J_W              = EXP_CAP + 1;
	localparam int RND_W            = $clog2(MIN_ROUNDS + 1);
	localparam int STP_W            = $clog2(STEP_FLOOR + 1);
	localparam int DRAW_LSB         = 17;
	localparam int DRAW_W           = SEED_W - DRAW_LSB;
	localparam int Q_BASE           = 17;
	localparam int LCG_CHUNK_W      = 16;
	localparam int LCG_CHUNKS       = SEED_W / LCG_CHUNK_W;
	localparam int LCG_MUL_W        = 35;

	localparam logic [SEED_W-1:0]    SEED_RESET = 48'h1234_ABCD_330E;
	localparam logic [LCG_MUL_W-1:0] LCG_MUL    = 35'h5_DEEC_E66D;
	localparam logic [SEED_W-1:0]    LCG_ADD    = 48'hB;

	typedef enum logic [3:0] {
		OP_LOAD,
		OP_LCG,
		OP_MODQ,
		OP_MODX,
		OP_STEP,
		OP_GCD,
		OP_SETY,
		OP_FDIV,
		OP_BAD
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic n_small;
		logic g_one;
		logic split;
	} sts_t;

endpackage

[hw/rtl/prbf_if.sv]
// ----------------------------------------------------------------------------
// Pollard rho factor splitter: channel interfaces
// Valid/ready channels for the number to factor and for the factor pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface prbf_num_if import prbf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [NUM_W-1:0] number_value;

	modport source (output valid, output number_value, input ready);
	modport sink (input valid, input number_value, output ready);
endinterface

interface prbf_res_if import prbf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [NUM_W-1:0] small_factor;
	logic [NUM_W-1:0] large_factor;
	logic             found;
	logic             bad_input;

	modport source (output valid, output small_factor, output large_factor,
		output found, output bad_input, input ready);
	modport sink (input valid, input small_factor, input large_factor,
		input found, input bad_input, output ready);
endinterface

[hw/rtl/pollard_rho_brent_factor64.sv]
// ----------------------------------------------------------------------------
// Pollard rho factor splitter, 64-bit, Brent cycle saving
// Splits a composite into a smaller and a larger factor.
// ----------------------------------------------------------------------------
//  channel  | dir | beat payload
//  ---------+-----+------------------------------------------------------
//  in_ch    | in  | number_value[63:0]
//  out_ch   | out | small_factor[63:0], large_factor[63:0], found, bad_input
//  cfg      | in  | cfg_wr_en, cfg_wr_data[47:0] (generator seed)
//
//  Each rho step runs a shift-and-add modular squaring over the bits of x,
//  then a binary gcd by shifts and subtracts; each draw runs a generator
//  update and a restoring division, and the final n/g is a division too.
//  An item with n below 2 skips the search and is flagged as bad input.
//  One item is worked at a time; the finished result sits in an output
//  register, so the next number is taken while it waits on out_ch.ready.
//  No clearing pass follows reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pollard_rho_brent_factor64_defines.svh"

module pollard_rho_brent_factor64 import prbf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [SEED_W-1:0] cfg_wr_data,
	prbf_num_if.sink          in_ch,
	prbf_res_if.source        out_ch
);

	cmd_t cmd;
	sts_t sts;

	prbf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	prbf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.number_value (in_ch.number_value),
		.cmd          (cmd),
		.sts          (sts),
		.small_factor (out_ch.small_factor),
		.large_factor (out_ch.large_factor),
		.found        (out_ch.found),
		.bad_input    (out_ch.bad_input)
	);

	`PRBF_ASSERT_IMP(a_no_issue_busy, cmd.start, !sts.busy, "op issued while datapath busy")
	`PRBF_ASSERT_IMP(a_out_after_done, $rose(out_ch.valid), $past(sts.done), "result raised without op completion")
	`PRBF_ASSERT_IMP(a_bad_no_factor, out_ch.valid && out_ch.bad_input, !out_ch.found && out_ch.small_factor == '0, "bad input beat carries a factor")

endmodule

[hw/rtl/prbf_div.sv]
// ----------------------------------------------------------------------------
// Pollard rho factor splitter: divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prbf_div import prbf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [NUM_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quot,
	output logic [NUM_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] rem_q, quo_q, dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [NUM_W:0]   trial, diff;
	logic             ge;

	// shift in the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

[hw/rtl/prbf_dp.sv]
// ----------------------------------------------------------------------------
// Pollard rho factor splitter: datapath
// Holds n, x, y, q, g and the generator; runs one op per command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prbf_dp import prbf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [SEED_W-1:0] cfg_wr_data,
	input  logic [NUM_W-1:0]  number_value,
	input  cmd_t              cmd,
	output sts_t              sts,
	output logic [NUM_W-1:0]  small_factor,
	output logic [NUM_W-1:0]  large_factor,
	output logic              found,
	output logic              bad_input
);

	logic [SEED_W-1:0] prng_q;
	logic [NUM_W-1:0]  n_q, x_q, y_q, q_q, g_q;
	logic [NUM_W-1:0]  a_q, b_q, c_q;
	logic [NUM_W-1:0]  small_q, large_q;
	logic              found_q, bad_q;
	logic [1:0]        k_q;
	op_t               op_q;
	logic              busy_q, done_q;

	logic [DRAW_W-1:0]              draw;
	logic [LCG_CHUNK_W-1:0]         chunk;
	logic [LCG_CHUNK_W+LCG_MUL_W-1:0] prod;
	logic [SEED_W-1:0]              part;
	logic [NUM_W-1:0]               z;
	logic                           div_go, div_done;
	logic [NUM_W-1:0]               div_a, div_b, quot, rem;
	logic                           last_chunk;

	// (s + t) mod n for s, t < n, exact across the carry out
	function automatic logic [NUM_W-1:0] add_mod(input logic [NUM_W-1:0] s,
		input logic [NUM_W-1:0] t, input logic [NUM_W-1:0] m);
		logic [NUM_W:0] sum;
		sum = {1'b0, s} + {1'b0, t};
		if (sum >= {1'b0, m})
			sum = sum - {1'b0, m};
		return sum[NUM_W-1:0];
	endfunction

	assign draw = prng_q[SEED_W-1:DRAW_LSB];

	// one 16-bit slice of the generator state times the multiplier
	assign chunk      = prng_q[{k_q, 4'b0000} +: LCG_CHUNK_W];
	assign prod       = chunk * LCG_MUL;
	assign part       = prod[SEED_W-1:0] << {k_q, 4'b0000};
	assign last_chunk = k_q == 2'(LCG_CHUNKS - 1);

	// distance between the walkers, taken mod n
	assign z = (x_q >= y_q) ? x_q - y_q : x_q - y_q + n_q;

	// divider operands
	assign div_go = cmd.start && (cmd.op == OP_MODQ || cmd.op == OP_MODX
		|| cmd.op == OP_FDIV);
	always_comb begin
		div_a = n_q;
		div_b = g_q;
		case (cmd.op)
			OP_MODQ: begin
				div_a = NUM_W'(draw[3:0]) + NUM_W'(Q_BASE);
				div_b = n_q;
			end
			OP_MODX: begin
				div_a = NUM_W'(draw);
				div_b = n_q - 1'b1;
			end
			default: ;
		endcase
	end

	prbf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	// op sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_LOAD;
			prng_q <= SEED_RESET;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr_en)
				prng_q <= cfg_wr_data;
			if (cmd.start) begin
				op_q <= cmd.op;
				case (cmd.op)
					OP_LOAD, OP_SETY, OP_BAD: begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					default: busy_q <= 1'b1;
				endcase
			end else if (busy_q) begin
				case (op_q)
					OP_LCG: begin
						if (last_chunk) begin
							prng_q <= a_q[SEED_W-1:0] + part + LCG_ADD;
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					OP_STEP: begin
						if (b_q == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					OP_GCD: begin
						if (a_q == '0 || b_q == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					OP_MODQ, OP_MODX, OP_FDIV: begin
						if (div_done) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					default: busy_q <= 1'b0;
				endcase
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			case (cmd.op)
				OP_LOAD: n_q <= number_value;
				OP_SETY: y_q <= x_q;
				OP_BAD: begin
					small_q <= '0;
					large_q <= '0;
					found_q <= 1'b0;
					bad_q   <= 1'b1;
				end
				OP_LCG: begin
					a_q <= '0;
					k_q <= '0;
				end
				OP_STEP: begin
					a_q <= x_q;
					b_q <= x_q;
					c_q <= q_q;
				end
				OP_GCD: begin
					a_q <= z;
					b_q <= n_q;
				end
				default: ;
			endcase
		end else if (busy_q) begin
			case (op_q)
				OP_LCG: begin
					a_q[SEED_W-1:0] <= a_q[SEED_W-1:0] + part;
					k_q <= k_q + 1'b1;
				end
				OP_STEP: begin
					if (b_q == '0) begin
						x_q <= c_q;
					end else begin
						if (b_q[0])
							c_q <= add_mod(c_q, a_q, n_q);
						a_q <= add_mod(a_q, a_q, n_q);
						b_q <= b_q >> 1;
					end
				end
				OP_GCD: begin
					if (a_q == '0 || b_q == '0)
						g_q <= (b_q == '0) ? a_q : b_q;
					else if (!b_q[0])
						b_q <= b_q >> 1;
					else if (!a_q[0])
						a_q <= a_q >> 1;
					else if (a_q > b_q)
						a_q <= a_q - b_q;
					else
						b_q <= b_q - a_q;
				end
				OP_MODQ: begin
					if (div_done)
						q_q <= rem;
				end
				OP_MODX: begin
					if (div_done) begin
						x_q <= rem + 1'b1;
						y_q <= rem + 1'b1;
					end
				end
				OP_FDIV: begin
					if (div_done) begin
						small_q <= (quot < g_q) ? quot : g_q;
						large_q <= (quot < g_q) ? g_q : quot;
						found_q <= (g_q > NUM_W'(1)) && (g_q < n_q);
						bad_q   <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// status back to the controller
	assign sts.busy    = busy_q;
	assign sts.done    = done_q;
	assign sts.n_small = n_q < NUM_W'(2);
	assign sts.g_one   = g_q == NUM_W'(1);
	assign sts.split   = (g_q > NUM_W'(1)) && (g_q < n_q);

	assign small_factor = small_q;
	assign large_factor = large_q;
	assign found        = found_q;
	assign bad_input    = bad_q;

endmodule

[hw/rtl/prbf_ctrl.sv]
// ----------------------------------------------------------------------------
// Pollard rho factor splitter: controller
// Sequences draws, rho steps, gcds and Brent rounds; owns the result valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prbf_ctrl import prbf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_LOAD  = 12'b0000_0000_0010,
		S_LCGQ  = 12'b0000_0000_0100,
		S_MODQ  = 12'b0000_0000_1000,
		S_LCGX  = 12'b0000_0001_0000,
		S_MODX  = 12'b0000_0010_0000,
		S_STEP  = 12'b0000_0100_0000,
		S_GCD   = 12'b0000_1000_0000,
		S_SETY  = 12'b0001_0000_0000,
		S_ROUND = 12'b0010_0000_0000,
		S_OUTW  = 12'b0100_0000_0000,
		S_FIN   = 12'b1000_0000_0000
	} state_t;

	state_t           state_q, state_d;
	logic [J_W-1:0]   j_q, j_d, j_inc, lim;
	logic [EXP_W-1:0] e_q, e_d;
	logic [RND_W-1:0] rnd_q, rnd_d;
	logic [STP_W-1:0] stp_q, stp_d;
	logic             bad_q, bad_d;
	logic             ov_q, ov_d;
	logic             pow2;

	assign j_inc = j_q + 1'b1;
	assign lim   = J_W'(1) << e_q;
	assign pow2  = (j_q & (j_q - 1'b1)) == '0;

	// next state and command issue
	always_comb begin
		state_d   = state_q;
		j_d       = j_q;
		e_d       = e_q;
		rnd_d     = rnd_q;
		stp_d     = stp_q;
		bad_d     = bad_q;
		ov_d      = ov_q;
		cmd.start = 1'b0;
		cmd.op    = OP_LOAD;
		if (ov_q && out_ready)
			ov_d = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					cmd.op    = OP_LOAD;
					state_d   = S_LOAD;
				end
			end
			S_LOAD: begin
				if (sts.done) begin
					if (sts.n_small) begin
						bad_d   = 1'b1;
						state_d = S_OUTW;
					end else begin
						bad_d     = 1'b0;
						rnd_d     = '0;
						e_d       = EXP_W'(ROUND_BASE_SHIFT);
						stp_d     = '0;
						cmd.start = 1'b1;
						cmd.op    = OP_LCG;
						state_d   = S_LCGQ;
					end
				end
			end
			S_LCGQ: begin
				if (sts.done) begin
					cmd.start = 1'b1;
					cmd.op    = OP_MODQ;
					state_d   = S_MODQ;
				end
			end
			S_MODQ: begin
				if (sts.done) begin
					cmd.start = 1'b1;
					cmd.op    = OP_LCG;
					state_d   = S_LCGX;
				end
			end
			S_LCGX: begin
				if (sts.done) begin
					cmd.start = 1'b1;
					cmd.op    = OP_MODX;
					j_d       = J_W'(1);
					state_d   = S_MODX;
				end
			end
			S_MODX: begin
				if (sts.done) begin
					cmd.start = 1'b1;
					cmd.op    = OP_STEP;
					state_d   = S_STEP;
				end
			end
			S_STEP: begin
				if (sts.done) begin
					cmd.start = 1'b1;
					cmd.op    = OP_GCD;
					state_d   = S_GCD;
				end
			end
			S_GCD: begin
				if (sts.done) begin
					if (stp_q != STP_W'(STEP_FLOOR))
						stp_d = stp_q + 1'b1;
					if (!sts.g_one) begin
						state_d = S_ROUND;
					end else if (pow2) begin
						cmd.start = 1'b1;
						cmd.op    = OP_SETY;
						state_d   = S_SETY;
					end else begin
						j_d = j_inc;
						if (j_inc == lim) begin
							state_d = S_ROUND;
						end else begin
							cmd.start = 1'b1;
							cmd.op    = OP_STEP;
							state_d   = S_STEP;
						end
					end
				end
			end
			S_SETY: begin
				if (sts.done) begin
					j_d = j_inc;
					if (j_inc == lim) begin
						state_d = S_ROUND;
					end else begin
						cmd.start = 1'b1;
						cmd.op    = OP_STEP;
						state_d   = S_STEP;
					end
				end
			end
			S_ROUND: begin
				if (sts.split) begin
					state_d = S_OUTW;
				end else begin
					if (rnd_q != RND_W'(MIN_ROUNDS))
						rnd_d = rnd_q + 1'b1;
					if (e_q != EXP_W'(EXP_CAP))
						e_d = e_q + 1'b1;
					if (rnd_q < RND_W'(MIN_ROUNDS - 1) || stp_q < STP_W'(STEP_FLOOR)) begin
						cmd.start = 1'b1;
						cmd.op    = OP_LCG;
						state_d   = S_LCGQ;
					end else begin
						state_d = S_OUTW;
					end
				end
			end
			S_OUTW: begin
				// hold the new result back until the last one is taken
				if (!ov_q) begin
					cmd.start = 1'b1;
					cmd.op    = bad_q ? OP_BAD : OP_FDIV;
					state_d   = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.done) begin
					ov_d    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q     <= '0;
			e_q     <= '0;
			rnd_q   <= '0;
			stp_q   <= '0;
			bad_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			j_q     <= j_d;
			e_q     <= e_d;
			rnd_q   <= rnd_d;
			stp_q   <= stp_d;
			bad_q   <= bad_d;
			ov_q    <= ov_d;
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = ov_q;

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// Pollard rho factor splitter: testbench
// Feeds numbers to the splitter over its valid/ready channel. An in-house
// predictor keeps its own copy of the seed generator and works out each factor
// pair. Every result beat is checked field by field against the oldest
// pending prediction. Both channels idle at random, and the seed is changed
// between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import prbf_pkg::*;

	localparam int CYCLE_LIMIT = 80_000_000;
	localparam int HOLD_CYCLES = 50_000;

	typedef struct packed {
		logic [NUM_W-1:0] small_factor;
		logic [NUM_W-1:0] large_factor;
		logic             found;
		logic             bad_input;
	} split_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [SEED_W-1:0] cfg_wr_data = '0;

	prbf_num_if in_ch();
	prbf_res_if out_ch();

	pollard_rho_brent_factor64 uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch)
	);

	split_t            pending_splits[$];
	logic [SEED_W-1:0] lcg_state;
	int                err_count = 0;
	int                numbers_sent = 0;
	int                splits_checked = 0;
	int                splits_found = 0;
	int                cycle_count = 0;
	int                hold_left = 0;
	bit                hold_req = 1'b0;
	bit                idling_on = 1'b1;

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run-away guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic logic [NUM_W-1:0] lcg_draw();
		logic [SEED_W-1:0] nxt;
		nxt = lcg_state * SEED_W'(LCG_MUL) + LCG_ADD;
		lcg_state = nxt;
		return NUM_W'(nxt >> DRAW_LSB);
	endfunction

	function automatic logic [NUM_W-1:0] sum_mod(logic [NUM_W-1:0] a, logic [NUM_W-1:0] b,
		logic [NUM_W-1:0] n);
		logic [NUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, n})
			s = s - {1'b0, n};
		return s[NUM_W-1:0];
	endfunction

	function automatic logic [NUM_W-1:0] odd_divisor(logic [NUM_W-1:0] a, logic [NUM_W-1:0] b);
		while (a != 0 && b != 0) begin
			while (!b[0])
				b = b >> 1;
			while (!a[0])
				a = a >> 1;
			if (a > b)
				a = a - b;
			else
				b = b - a;
		end
		return (b == 0) ? a : b;
	endfunction

	function automatic split_t split_number(logic [NUM_W-1:0] n);
		split_t           r;
		logic [NUM_W-1:0] g, p, q, x, y, a, b, c, z, steps, lim;
		int               rnd, e;
		r = '0;
		if (n < 2) begin
			r.bad_input = 1'b1;
			return r;
		end
		g = 0;
		steps = 0;
		for (rnd = 0; rnd < MIN_ROUNDS || steps < STEP_FLOOR; rnd++) begin
			q = ((lcg_draw() & 15) + Q_BASE) % n;
			x = lcg_draw() % (n - 1) + 1;
			y = x;
			e = rnd + ROUND_BASE_SHIFT;
			if (e > EXP_CAP)
				e = EXP_CAP;
			lim = 64'd1 << e;
			for (logic [NUM_W-1:0] j = 1; j < lim; j++) begin
				steps++;
				a = x;
				b = x;
				c = q;
				// square by shift-and-add, then add q
				while (b != 0) begin
					if (b[0])
						c = sum_mod(c, a, n);
					a = sum_mod(a, a, n);
					b = b >> 1;
				end
				x = c;
				z = (x < y) ? n + x - y : x - y;
				g = odd_divisor(z, n);
				if (g != 1)
					break;
				if ((j & (j - 1)) == 0)
					y = x;
			end
			if (g > 1 && g < n)
				break;
		end
		p = n / g;
		r.small_factor = (p < g) ? p : g;
		r.large_factor = (p < g) ? g : p;
		r.found = (g > 1 && g < n);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// result side: check each beat, then pick ready for the next cycle
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, logic [NUM_W-1:0] got, logic [NUM_W-1:0] want);
		$display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
		err_count++;
	endtask

	always @(posedge clk) begin
		split_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (pending_splits.size() == 0) begin
					report_mismatch("unexpected beat", out_ch.small_factor, '0);
				end else begin
					want = pending_splits.pop_front();
					splits_checked++;
					if (want.found)
						splits_found++;
					if (out_ch.small_factor !== want.small_factor)
						report_mismatch("small_factor", out_ch.small_factor, want.small_factor);
					if (out_ch.large_factor !== want.large_factor)
						report_mismatch("large_factor", out_ch.large_factor, want.large_factor);
					if (out_ch.found !== want.found)
						report_mismatch("found", NUM_W'(out_ch.found), NUM_W'(want.found));
					if (out_ch.bad_input !== want.bad_input)
						report_mismatch("bad_input", NUM_W'(out_ch.bad_input),
							NUM_W'(want.bad_input));
				end
			end
			// long hold-off when requested, random stalls otherwise
			if (hold_req || hold_left > 0) begin
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= !(idling_on && $urandom_range(99) < 13);
			end
		end
	end

	// count down the long receiver hold-off
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req <= 1'b0;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// ------------------------------------------------------------------
	// number side
	// ------------------------------------------------------------------
	task automatic send_number(logic [NUM_W-1:0] n);
		if (idling_on && $urandom_range(99) < 13) begin
			in_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < 50);
		end
		in_ch.valid <= 1'b1;
		in_ch.number_value <= n;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pending_splits.push_back(split_number(n));
		numbers_sent++;
	endtask

	// drop valid and wait until every prediction is met
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_splits.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_seed(logic [SEED_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		lcg_state = v;
		@(posedge clk);
	endtask

	// composite with a small odd factor, so the split comes quickly
	function automatic logic [NUM_W-1:0] easy_composite();
		int               primes[12] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 97};
		int               w;
		logic [NUM_W-1:0] m;
		w = $urandom_range(57, 2);
		m = {$urandom, $urandom};
		m = (m & ((64'd1 << w) - 1)) | (64'd1 << (w - 1));
		return m * primes[$urandom_range(11)];
	endfunction

	function automatic logic [NUM_W-1:0] random_number();
		if ($urandom_range(99) < 15)
			return NUM_W'($urandom_range(4095));
		return easy_composite();
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		logic [NUM_W-1:0] nums[$];
		nums = '{0, 1, 2, 3, 4, 5, 6, 9, 15, 21, 35, 91,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001,
			64'h3 * 64'h5555_5555_5555_5553, 64'hFFFF_FFFF_FFFF_FFFD,
			64'd1000003 * 64'd7};
		foreach (nums[k])
			send_number(nums[k]);
		drain();
	endtask

	task automatic test_random(int count);
		repeat (count)
			send_number(random_number());
		drain();
	endtask

	task automatic test_no_idle(int count);
		idling_on = 1'b0;
		repeat (count)
			send_number(easy_composite());
		drain();
		idling_on = 1'b1;
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (6)
			send_number(easy_composite());
		drain();
	endtask

	task automatic test_seed(logic [SEED_W-1:0] seed, int count);
		write_seed(seed);
		test_random(count);
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.number_value = '0;
		out_ch.ready = 1'b0;
		lcg_state = SEED_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(25);
		test_no_idle(15);
		test_backpressure();
		test_seed('0, 15);
		test_seed({SEED_W{1'b1}}, 15);
		test_seed(SEED_W'({$urandom, $urandom}), 15);

		$display("Sent %0d numbers, checked %0d factor pairs (%0d splits) over 4 seeds",
			numbers_sent, splits_checked, splits_found);
		if (err_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/prbf_pkg.sv
hw/rtl/prbf_if.sv
hw/rtl/prbf_div.sv
hw/rtl/prbf_dp.sv
hw/rtl/prbf_ctrl.sv
hw/rtl/pollard_rho_brent_factor64.sv
verif/tb.sv
